// ----- rtl/go_back_n_sender_window_assert.svh -----
// Assertion macros for the go-back-N sender window checker.
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

// Same-cycle implication.
`define GBN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gbn_sw_pkg.sv -----
// Shared types and constants for the go-back-N sender window.
// No dependencies; used by the top level and the checker.
package gbn_sw_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;

  localparam int SEQ_W  = 8;
  localparam int LEN_W  = 16;
  localparam int STAT_W = 3;
  localparam int OCC_W  = 5;
  localparam int WLIM_W = 5;
  localparam int TMO_W  = 16;
  localparam int CFG_W  = 16;

  localparam logic [WLIM_W-1:0] WLIM_RST = 5'd16;
  localparam logic [TMO_W-1:0]  TMO_RST  = 16'd500;

  // configuration register indexes
  localparam logic CFG_WINDOW_LIMIT  = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    K_SEND = 2'd0,
    K_ACK  = 2'd1,
    K_END  = 2'd2,
    K_TICK = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FINISHED = 3'd4,
    ST_BADSUM   = 3'd5,
    ST_BADFLAG  = 3'd6
  } status_t;

endpackage

// ----- rtl/gbn_sw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbn_sw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/go_back_n_sender_window.sv -----
// Go-back-N sender window: tracks outstanding (seq, length) pairs in a circular RAM.
// Each word is decided in EXEC and posted from RESP, after a window scan where needed; a
// timeout resend follows the scan, RSND_RD reading and RSND_WT posting each resent word,
// gated by out_ready. One word in flight: the next is taken once its last result is posted.
// Reset (sync, active low) clears control and timer state; the RAM is not cleared and
// needs no clearing pass, since entries are read only after being written.
module go_back_n_sender_window #(
  parameter int WINDOW_DEPTH = gbn_sw_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write port
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [gbn_sw_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic [gbn_sw_pkg::SEQ_W-1:0]     in_seq,
  input  logic [gbn_sw_pkg::LEN_W-1:0]     in_seg_length,
  input  logic                             in_checksum_ok,
  input  logic                             in_flag_ok,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [gbn_sw_pkg::STAT_W-1:0]    out_status,
  output logic                             out_resend_valid,
  output logic [gbn_sw_pkg::SEQ_W-1:0]     out_resend_seq,
  output logic [gbn_sw_pkg::LEN_W-1:0]     out_resend_length,
  output logic [gbn_sw_pkg::OCC_W-1:0]     out_occupancy,
  output logic                             out_last
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SEQ_W = gbn_sw_pkg::SEQ_W;
  localparam int LEN_W = gbn_sw_pkg::LEN_W;
  localparam int RAM_W = SEQ_W + LEN_W;
  localparam int EXT_W = CNT_W + gbn_sw_pkg::OCC_W;

  // EXEC decides on the latched word, SRCH scans oldest-first (one RAM read per cycle,
  // compare in the cycle after the read), RSND_RD/RSND_WT walk the resend range, RESP posts
  // a single result word.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_RSND_RD,
    S_RSND_WT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [gbn_sw_pkg::WLIM_W-1:0] wlim_r, wlim_nxt;
  logic [gbn_sw_pkg::TMO_W-1:0]  tmo_r, tmo_nxt;

  // window and timer state
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SEQ_W-1:0]  timed_r, timed_nxt;
  logic              running_r, running_nxt;
  logic [gbn_sw_pkg::TMO_W-1:0] elapsed_r, elapsed_nxt;
  logic              halted_r, halted_nxt;

  // latched input word
  gbn_sw_pkg::kind_t kind_r, kind_nxt;
  logic [SEQ_W-1:0]  key_r, key_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              sum_r, sum_nxt;
  logic              flag_r, flag_nxt;

  // sequencer scratch
  gbn_sw_pkg::status_t st_r, st_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;        // next scan position to read
  logic              cmp_vld_r, cmp_vld_nxt; // RAM data this cycle belongs to a scan read
  logic [CNT_W-1:0]  cmp_pos_r, cmp_pos_nxt; // position of that read
  logic [SEQ_W-1:0]  oldest_r, oldest_nxt;   // seq of the oldest entry, caught during scan
  logic [CNT_W-1:0]  rs_pos_r, rs_pos_nxt;   // resend walk position

  // output register
  logic                  out_valid_r, out_valid_nxt;
  gbn_sw_pkg::status_t   out_status_r, out_status_nxt;
  logic                  out_rsv_r, out_rsv_nxt;
  logic [SEQ_W-1:0]      out_rseq_r, out_rseq_nxt;
  logic [LEN_W-1:0]      out_rlen_r, out_rlen_nxt;
  logic [gbn_sw_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;
  logic                  out_last_r, out_last_nxt;

  // RAM interface
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [RAM_W-1:0]  ram_rdata;
  logic [SEQ_W-1:0]  rd_seq;
  logic [LEN_W-1:0]  rd_len;

  // helpers
  logic [EXT_W-1:0]  cnt_ext, wlim_ext, depth_ext, lim_ext;
  logic              win_full;
  logic              out_free;
  logic [gbn_sw_pkg::TMO_W-1:0] el_inc;
  logic [CNT_W-1:0]  drop_cnt;
  logic [CNT_W-1:0]  cnt_after;
  logic [SEQ_W-1:0]  oldest_now;
  logic              scan_hit;
  logic              scan_end;

  // circular slot: (head + pos) mod depth; head < depth and pos <= depth, so one
  // conditional subtract is enough
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [CNT_W-1:0] pos);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CNT_W + 1)'(WINDOW_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(WINDOW_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  gbn_sw_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_seq = ram_rdata[RAM_W-1:LEN_W];
  assign rd_len = ram_rdata[LEN_W-1:0];

  // effective limit = min(window_limit, depth); limit 0 means always full
  assign cnt_ext   = {{gbn_sw_pkg::OCC_W{1'b0}}, count_r};
  assign wlim_ext  = {{CNT_W{1'b0}}, wlim_r};
  assign depth_ext = EXT_W'(WINDOW_DEPTH);
  assign lim_ext   = (wlim_ext > depth_ext) ? depth_ext : wlim_ext;
  assign win_full  = (cnt_ext >= lim_ext);

  assign out_free = !out_valid_r || out_ready;
  assign el_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;

  // scan compare works on the RAM read issued in the previous cycle
  assign scan_hit   = cmp_vld_r && (rd_seq == key_r);
  assign scan_end   = cmp_vld_r && (cmp_pos_r == count_r - CNT_W'(1));
  assign drop_cnt   = cmp_pos_r + CNT_W'(1);
  assign cnt_after  = count_r - drop_cnt;
  assign oldest_now = (cmp_vld_r && cmp_pos_r == '0) ? rd_seq : oldest_r;

  assign ram_raddr = slot_of(head_r, (state_r == S_SRCH) ? ptr_r : rs_pos_r);
  assign ram_waddr = slot_of(head_r, count_r);
  assign ram_wdata = {key_r, len_r};

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    wlim_nxt     = wlim_r;
    tmo_nxt      = tmo_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    timed_nxt    = timed_r;
    running_nxt  = running_r;
    elapsed_nxt  = elapsed_r;
    halted_nxt   = halted_r;
    kind_nxt     = kind_r;
    key_nxt      = key_r;
    len_nxt      = len_r;
    sum_nxt      = sum_r;
    flag_nxt     = flag_r;
    st_nxt       = st_r;
    ptr_nxt      = ptr_r;
    cmp_vld_nxt  = 1'b0;
    cmp_pos_nxt  = cmp_pos_r;
    oldest_nxt   = oldest_now;
    rs_pos_nxt   = rs_pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rsv_nxt    = out_rsv_r;
    out_rseq_nxt   = out_rseq_r;
    out_rlen_nxt   = out_rlen_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    ram_we       = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        gbn_sw_pkg::CFG_WINDOW_LIMIT:  wlim_nxt = cfg_wdata[gbn_sw_pkg::WLIM_W-1:0];
        gbn_sw_pkg::CFG_TIMEOUT_TICKS: tmo_nxt  = cfg_wdata[gbn_sw_pkg::TMO_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = gbn_sw_pkg::kind_t'(in_kind);
          key_nxt   = in_seq;
          len_nxt   = in_seg_length;
          sum_nxt   = in_checksum_ok;
          flag_nxt  = in_flag_ok;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        ptr_nxt   = '0;
        state_nxt = S_RESP;
        st_nxt    = gbn_sw_pkg::ST_OK;
        if (kind_r == gbn_sw_pkg::K_SEND) begin
          // sends still work while halted
          if (win_full) begin
            st_nxt = gbn_sw_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (halted_r) begin
          st_nxt = gbn_sw_pkg::ST_OK;
        end else if (kind_r inside {gbn_sw_pkg::K_ACK, gbn_sw_pkg::K_END}) begin
          if (!sum_r) begin
            st_nxt = gbn_sw_pkg::ST_BADSUM;
          end else if (!flag_r) begin
            st_nxt     = gbn_sw_pkg::ST_BADFLAG;
            halted_nxt = 1'b1;
          end else if (count_r == '0) begin
            if (kind_r == gbn_sw_pkg::K_END) begin
              st_nxt     = gbn_sw_pkg::ST_FINISHED;
              halted_nxt = 1'b1;
            end else begin
              st_nxt = gbn_sw_pkg::ST_EMPTY;
            end
          end else begin
            state_nxt = S_SRCH;
          end
        end else begin
          // tick: empty window means the timed segment is gone, stop the timer
          if (count_r == '0) begin
            running_nxt = 1'b0;
          end else begin
            key_nxt   = timed_r;
            state_nxt = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (scan_hit) begin
          state_nxt = S_RESP;
          st_nxt    = gbn_sw_pkg::ST_OK;
          if (kind_r == gbn_sw_pkg::K_TICK) begin
            if (running_r) begin
              elapsed_nxt = el_inc;
              if (el_inc >= tmo_r) begin
                rs_pos_nxt = cmp_pos_r;
                state_nxt  = S_RSND_RD;
              end
            end
          end else begin
            // drop everything up to and including the match
            head_nxt  = slot_of(head_r, drop_cnt);
            count_nxt = cnt_after;
            if (kind_r == gbn_sw_pkg::K_END && cnt_after == '0) begin
              st_nxt     = gbn_sw_pkg::ST_FINISHED;
              halted_nxt = 1'b1;
            end
          end
        end else if (scan_end) begin
          state_nxt = S_RESP;
          if (kind_r == gbn_sw_pkg::K_TICK) begin
            // timed segment gone: restart on the oldest entry
            st_nxt      = gbn_sw_pkg::ST_OK;
            running_nxt = 1'b1;
            elapsed_nxt = '0;
            timed_nxt   = oldest_now;
          end else begin
            st_nxt = gbn_sw_pkg::ST_NOTFOUND;
          end
        end else begin
          ptr_nxt     = ptr_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
          cmp_pos_nxt = ptr_r;
        end
      end

      S_RSND_RD: begin
        state_nxt = S_RSND_WT;
      end

      S_RSND_WT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = gbn_sw_pkg::ST_OK;
          out_rsv_nxt    = 1'b1;
          out_rseq_nxt   = rd_seq;
          out_rlen_nxt   = rd_len;
          out_occ_nxt    = cnt_ext[gbn_sw_pkg::OCC_W-1:0];
          out_last_nxt   = (rs_pos_r == count_r - CNT_W'(1));
          if (rs_pos_r == count_r - CNT_W'(1)) begin
            running_nxt = 1'b1;
            elapsed_nxt = '0;
            timed_nxt   = oldest_r;
            state_nxt   = S_IDLE;
          end else begin
            rs_pos_nxt = rs_pos_r + CNT_W'(1);
            state_nxt  = S_RSND_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_rsv_nxt    = 1'b0;
          out_rseq_nxt   = '0;
          out_rlen_nxt   = '0;
          out_occ_nxt    = cnt_ext[gbn_sw_pkg::OCC_W-1:0];
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlim_r      <= gbn_sw_pkg::WLIM_RST;
      tmo_r       <= gbn_sw_pkg::TMO_RST;
      head_r      <= '0;
      count_r     <= '0;
      timed_r     <= '0;
      running_r   <= 1'b1;
      elapsed_r   <= '0;
      halted_r    <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wlim_r      <= wlim_nxt;
      tmo_r       <= tmo_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      timed_r     <= timed_nxt;
      running_r   <= running_nxt;
      elapsed_r   <= elapsed_nxt;
      halted_r    <= halted_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    sum_r        <= sum_nxt;
    flag_r       <= flag_nxt;
    st_r         <= st_nxt;
    ptr_r        <= ptr_nxt;
    cmp_pos_r    <= cmp_pos_nxt;
    oldest_r     <= oldest_nxt;
    rs_pos_r     <= rs_pos_nxt;
    out_status_r <= out_status_nxt;
    out_rsv_r    <= out_rsv_nxt;
    out_rseq_r   <= out_rseq_nxt;
    out_rlen_r   <= out_rlen_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_resend_valid  = out_rsv_r;
  assign out_resend_seq    = out_rseq_r;
  assign out_resend_length = out_rlen_r;
  assign out_occupancy     = out_occ_r;
  assign out_last          = out_last_r;

endmodule

// ----- rtl/gbn_sw_checker.sv -----
// Port-level checker for the go-back-N sender window, bound to the top level.
// Depends on gbn_sw_pkg and go_back_n_sender_window_assert.svh.
`include "go_back_n_sender_window_assert.svh"

module gbn_sw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gbn_sw_pkg::STAT_W-1:0] out_status,
  input logic                          out_resend_valid,
  input logic [gbn_sw_pkg::SEQ_W-1:0]  out_resend_seq,
  input logic [gbn_sw_pkg::LEN_W-1:0]  out_resend_length,
  input logic [gbn_sw_pkg::OCC_W-1:0]  out_occupancy,
  input logic                          out_last
);

  // stalled result word holds
  `GBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_status) && $stable(out_resend_valid) &&
                   $stable(out_resend_seq) && $stable(out_resend_length) &&
                   $stable(out_occupancy) && $stable(out_last),
                   "result word changed while stalled")

  // retransmit words are always status ok
  `GBN_ASSERT_NOW(a_resend_ok, out_valid && out_resend_valid,
                  out_status == gbn_sw_pkg::ST_OK, "resend word with non-ok status")

  // a plain result is a single, final word with zeroed resend fields
  `GBN_ASSERT_NOW(a_plain_last, out_valid && !out_resend_valid,
                  out_last && out_resend_seq == '0 && out_resend_length == '0,
                  "plain result not last or resend fields set")

  // no new word is taken while a resend burst is still going
  `GBN_ASSERT_NOW(a_burst_block, out_valid && !out_last, !in_ready,
                  "input ready during resend burst")

  // one word at a time: the cycle after an accept the block is busy
  `GBN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "ready right after accept")

endmodule

bind go_back_n_sender_window gbn_sw_checker u_gbn_sw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_resend_valid  (out_resend_valid),
  .out_resend_seq    (out_resend_seq),
  .out_resend_length (out_resend_length),
  .out_occupancy     (out_occupancy),
  .out_last          (out_last)
);
